>>> hdl/sil_pkg.sv
package sil_pkg;

  // Address arithmetic width of the load target
  localparam int unsigned ADDRESS_BITS_DEFAULT = 32;

  // Load base after reset
  localparam logic [31:0] LOAD_BASE_RESET = 32'h0008_0000;

  // Bytes in each big-endian header word
  localparam int unsigned HEADER_BYTES = 4;

  typedef logic [1:0] phase_t;

  localparam phase_t PH_SIZE   = 2'd0;
  localparam phase_t PH_SUM    = 2'd1;
  localparam phase_t PH_DATA   = 2'd2;
  localparam phase_t PH_UNUSED = 2'd3;

endpackage

>>> hdl/serial_image_loader_top.sv
// Each result beat is registered in the cycle after its rx_byte beat is accepted.
// Throughput: one byte per cycle; the parse state and the single output register
//   are both updated in the accepting cycle, so a stalled output only holds input.
// Reset (rst, synchronous, active high): return to the size header, clear counters,
//   image length and checksum, drop any pending result, load base to 0x00080000.
module serial_image_loader_top #(
  parameter int unsigned ADDRESS_BITS = sil_pkg::ADDRESS_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] load_base,
  // received byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // memory write / status channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_enable,
  output logic [31:0] write_address,
  output logic [7:0]  write_data,
  output logic        frame_done,
  output logic        checksum_ok,
  output logic [31:0] checksum_left
);

  localparam int unsigned CNT_W = $clog2(sil_pkg::HEADER_BYTES);

  // Configuration register: always ready, takes effect for the next byte.
  logic [31:0] base;

  // Parse state
  sil_pkg::phase_t   phase,           phase_next;
  logic [CNT_W-1:0]  header_count,    header_count_next;
  logic [31:0]       image_length,    image_length_next;
  logic [31:0]       check_remainder, check_remainder_next;
  logic [30:0]       payload_offset,  payload_offset_next;

  // Result of the byte under decode
  logic                    we_next;
  logic [31:0]             wa_next;
  logic [7:0]              wd_next;
  logic                    done_next;
  logic                    ok_next;
  logic [ADDRESS_BITS-1:0] addr_sum;
  logic                    in_beat;

  assign cfg_ready = 1'b1;

  // The output register frees up when empty or when its beat is taken this cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;

  // Wrap the target address at the address width, then present the low 32 bits.
  assign addr_sum = ADDRESS_BITS'(base) + ADDRESS_BITS'(payload_offset);

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    image_length_next    = image_length;
    check_remainder_next = check_remainder;
    payload_offset_next  = payload_offset;
    we_next              = 1'b0;
    wa_next              = '0;
    wd_next              = '0;
    done_next            = 1'b0;
    ok_next              = 1'b0;

    case (phase)
      sil_pkg::PH_DATA: begin
        // Payload byte: issue the write and subtract it from the checksum.
        we_next              = 1'b1;
        wa_next              = 32'(addr_sum);
        wd_next              = rx_byte;
        check_remainder_next = check_remainder - {24'd0, rx_byte};
        payload_offset_next  = payload_offset + 31'd1;
        if ({1'b0, payload_offset_next} == image_length) begin
          done_next         = 1'b1;
          ok_next           = (check_remainder_next == 32'd0);
          phase_next        = sil_pkg::PH_SIZE;
          header_count_next = '0;
        end
      end
      sil_pkg::PH_SUM: begin
        // Shift the checksum in big-endian; an empty or negative size ends here.
        check_remainder_next = {check_remainder[23:0], rx_byte};
        header_count_next    = header_count + CNT_W'(1);
        if (header_count_next == '0) begin
          payload_offset_next = '0;
          if (image_length == 32'd0 || image_length[31]) begin
            done_next  = 1'b1;
            ok_next    = (check_remainder_next == 32'd0);
            phase_next = sil_pkg::PH_SIZE;
          end else begin
            phase_next = sil_pkg::PH_DATA;
          end
        end
      end
      default: begin
        // Size header; the unused phase code parses as size header too.
        image_length_next = (header_count == '0) ? {24'd0, rx_byte}
                                                 : {image_length[23:0], rx_byte};
        header_count_next = header_count + CNT_W'(1);
        if (header_count_next == '0) begin
          phase_next           = sil_pkg::PH_SUM;
          check_remainder_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= sil_pkg::LOAD_BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base <= load_base;
    end
  end

  // Advance the parse state on every accepted byte beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= sil_pkg::PH_SIZE;
      header_count    <= '0;
      image_length    <= '0;
      check_remainder <= '0;
      payload_offset  <= '0;
    end else if (in_beat) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      image_length    <= image_length_next;
      check_remainder <= check_remainder_next;
      payload_offset  <= payload_offset_next;
    end
  end

  // Output register: valid is control, the fields are payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      write_enable  <= we_next;
      write_address <= wa_next;
      write_data    <= wd_next;
      frame_done    <= done_next;
      checksum_ok   <= ok_next;
      checksum_left <= check_remainder_next;
    end
  end

`ifndef SYNTHESIS
  // A pass flag only accompanies the end of a frame.
  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && checksum_ok |-> frame_done)
    else $error("checksum_ok without frame_done");

  // Non-write beats carry a cleared address and data.
  a_idle_write_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> (write_address == 32'd0) && (write_data == 8'd0))
    else $error("address or data set on a non-write beat");

  // The header counter is parked at zero through the payload.
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == sil_pkg::PH_DATA |-> header_count == '0)
    else $error("header count nonzero in payload phase");

  // A byte taken in the payload phase always produces a write beat.
  a_payload_write: assert property (@(posedge clk) disable iff (rst)
    in_beat && phase == sil_pkg::PH_DATA |=> out_valid && write_enable)
    else $error("payload byte did not produce a write");
`endif

endmodule
